### rtl/dual_bitmap_block_allocator_unit_macros.svh
// Assertion macros used by the checker file of the allocator.
`ifndef DUAL_BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define DUAL_BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DBBA_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, ignored while reset is asserted.
`define DBBA_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication that also holds across reset.
`define DBBA_AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### rtl/dbba_pkg.sv
package dbba_pkg;

  localparam int GROUP_BITS = 32768;
  localparam int WORD_BITS  = 32;
  localparam int NWORDS     = GROUP_BITS / WORD_BITS;
  localparam int WIDX_W     = $clog2(NWORDS);
  localparam int BOFF_W     = $clog2(WORD_BITS);
  localparam int BLK_W      = $clog2(GROUP_BITS);
  localparam int CNT_W      = 16;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [BLK_W-1:0]     blk_t;
  typedef logic [BOFF_W:0]      bidx_t;

  localparam cnt_t CNT_MAX = '1;

  // Input operation codes.
  localparam logic [2:0] FN_ALLOC  = 3'd0;
  localparam logic [2:0] FN_FREE   = 3'd1;
  localparam logic [2:0] FN_COMMIT = 3'd2;
  localparam logic [2:0] FN_LOAD   = 3'd3;
  localparam logic [2:0] FN_SETCNT = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_BAD_RANGE = 3'd2,
    ST_META      = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_COUNT     = 3'd5,
    ST_BAD_OP    = 3'd6
  } st_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LATCH, DP_RANGE, DP_READ, DP_CHK, DP_FIND, DP_CLAIM, DP_UNDO,
    DP_FREE, DP_COMMIT, DP_CLEAR, DP_LOAD, DP_FB_SET, DP_FB_SUB, DP_FB_ADD
  } dp_op_t;

  typedef enum logic [3:0] {
    RG_BMAP, RG_IMAP, RG_ITAB, RG_SCAN1, RG_SCAN2, RG_RUN, RG_UNDO, RG_FREE, RG_ALL
  } rg_t;

  typedef struct packed {
    dp_op_t op;
    rg_t    rsel;
    st_t    code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic done;
    logic found;
    logic bad;
    logic cont;
    logic free_zero;
    logic want_zero;
    logic bounds_ok;
    logic free_bad;
    logic hits;
    logic load_bad;
    logic goal_pos;
    logic underflow;
    logic overflow;
  } dp_stat_t;

  typedef struct packed {
    cnt_t group_blocks;
    blk_t block_map_pos;
    blk_t inode_map_pos;
    blk_t inode_table_pos;
    blk_t inode_table_len;
  } cfg_t;

  typedef struct packed {
    cnt_t free_count;
    cnt_t already_free;
    cnt_t granted;
    blk_t first_block;
    st_t  status;
  } result_t;

  // Bits lo .. hi-1 of a word set.
  function automatic word_t range_mask(input bidx_t lo, input bidx_t hi);
    word_t m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (bidx_t'(i) >= lo) && (bidx_t'(i) < hi);
    end
    return m;
  endfunction

  // Index of the lowest set bit; the top bit acts as a sentinel.
  function automatic bidx_t lsb_index(input logic [WORD_BITS:0] v);
    logic [WORD_BITS:0] oh;
    bidx_t idx;
    oh = v & (~v + 1'b1);
    idx = '0;
    for (int j = 0; j <= BOFF_W; j++) begin
      for (int i = 0; i <= WORD_BITS; i++) begin
        if (((i >> j) & 1) != 0) begin
          idx[j] = idx[j] | oh[i];
        end
      end
    end
    return idx;
  endfunction

  // Population count as nibble counts followed by a short sum.
  function automatic bidx_t popcount(input word_t v);
    logic [2:0] nib [WORD_BITS/4];
    bidx_t s;
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
    end
    s = '0;
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      s = s + bidx_t'(nib[n]);
    end
    return s;
  endfunction

  function automatic logic in_span(input cnt_t b, input cnt_t first, input cnt_t len);
    return (len != '0) && (b >= first) && ((b - first) < len);
  endfunction

endpackage

### rtl/dbba_dp.sv
module dbba_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  dbba_pkg::cfg_t    cfg,
  input  dbba_pkg::dp_cmd_t cmd,
  input  logic [2:0]        in_func,
  input  logic [15:0]       in_start,
  input  logic [15:0]       in_count,
  input  logic [31:0]       in_word,
  output dbba_pkg::dp_stat_t stat,
  output dbba_pkg::result_t res
);
  import dbba_pkg::*;

  word_t live_mem [NWORDS];
  word_t snap_mem [NWORDS];
  word_t live_q, snap_q;

  logic [2:0] func_r;
  cnt_t start_r, cnt_r;
  word_t word_r;
  cnt_t cur_r, lim_r, rem_r, n_r, was_r, fb_r;
  blk_t first_r;
  logic found_r, bad_r, cont_r;

  cnt_t end_w, base, span, avail, k16, hs, hn, hlast, tp16, tl16;
  bidx_t lo, hi, tz, k, room, fidx;
  word_t mask, usable, sh, cmask, find_v;
  logic goal_ok;
  logic [WIDX_W-1:0] waddr;
  logic we_live, we_snap;
  word_t live_wd, snap_wd;

  assign end_w = (cfg.group_blocks > cnt_t'(GROUP_BITS)) ? cnt_t'(GROUP_BITS)
                                                         : cfg.group_blocks;
  assign tp16 = {1'b0, cfg.inode_table_pos};
  assign tl16 = {1'b0, cfg.inode_table_len};

  // Word window of the current position.
  assign base  = {1'b0, cur_r[BLK_W-1:BOFF_W], BOFF_W'(0)};
  assign span  = lim_r - base;
  assign lo    = {1'b0, cur_r[BOFF_W-1:0]};
  assign hi    = (span >= cnt_t'(WORD_BITS)) ? bidx_t'(WORD_BITS) : span[BOFF_W:0];
  assign mask  = range_mask(lo, hi);
  assign usable = ~live_q & ~snap_q;

  // Run claim: usable bits from the current offset, capped by want and end.
  assign sh    = usable >> cur_r[BOFF_W-1:0];
  assign tz    = lsb_index({1'b1, ~sh});
  assign avail = lim_r - cur_r;
  always_comb begin
    k16 = cnt_t'(tz);
    if (rem_r < k16) begin
      k16 = rem_r;
    end
    if (avail < k16) begin
      k16 = avail;
    end
  end
  assign k     = k16[BOFF_W:0];
  assign cmask = range_mask(lo, lo + k);
  assign room  = bidx_t'(WORD_BITS) - lo;

  assign find_v = usable & mask;
  assign fidx   = lsb_index({1'b0, find_v});
  assign goal_ok = !start_r[CNT_W-1] && (start_r < end_w);

  // Metadata overlap of the free range or the claimed run.
  assign hs    = (func_r == FN_FREE) ? start_r : {1'b0, first_r};
  assign hn    = (func_r == FN_FREE) ? cnt_r : n_r;
  assign hlast = hs + hn - 1'b1;

  always_comb begin
    stat.func      = func_r;
    stat.done      = cur_r >= lim_r;
    stat.found     = found_r;
    stat.bad       = bad_r;
    stat.cont      = cont_r;
    stat.free_zero = fb_r == '0;
    stat.want_zero = cnt_r == '0;
    stat.bounds_ok = ({1'b0, cfg.block_map_pos} < end_w) &&
                     ({1'b0, cfg.inode_map_pos} < end_w) && (tp16 < end_w) &&
                     (tl16 != '0) && (tl16 <= end_w - tp16);
    stat.free_bad  = (cnt_r == '0) || start_r[CNT_W-1] || (start_r >= end_w) ||
                     (cnt_r > end_w - start_r);
    stat.hits      = (hn == '0) || in_span({1'b0, cfg.block_map_pos}, hs, hn) ||
                     in_span({1'b0, cfg.inode_map_pos}, hs, hn) ||
                     in_span(hs, tp16, tl16) || in_span(hlast, tp16, tl16);
    stat.load_bad  = start_r[CNT_W-1] || (start_r >= cnt_t'(NWORDS));
    stat.goal_pos  = !start_r[CNT_W-1] && (start_r != '0);
    stat.underflow = fb_r < n_r;
    stat.overflow  = (n_r != '0) && (fb_r > CNT_MAX - n_r);
  end

  // Memory write side.
  always_comb begin
    we_live = 1'b0;
    we_snap = 1'b0;
    live_wd = live_q;
    snap_wd = live_q;
    waddr   = cur_r[BLK_W-1:BOFF_W];
    case (cmd.op)
      DP_CLAIM: begin
        we_live = 1'b1;
        live_wd = live_q | cmask;
      end
      DP_UNDO: begin
        we_live = 1'b1;
        live_wd = live_q & ~mask;
      end
      DP_FREE: begin
        we_live = 1'b1;
        we_snap = 1'b1;
        live_wd = live_q & ~mask;
        snap_wd = snap_q | mask;
      end
      DP_COMMIT: begin
        we_snap = 1'b1;
      end
      DP_CLEAR: begin
        we_live = 1'b1;
        we_snap = 1'b1;
        live_wd = '0;
        snap_wd = '0;
      end
      DP_LOAD: begin
        we_live = 1'b1;
        we_snap = 1'b1;
        live_wd = word_r;
        snap_wd = word_r;
        waddr   = start_r[WIDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_live) begin
      live_mem[waddr] <= live_wd;
    end
    if (we_snap) begin
      snap_mem[waddr] <= snap_wd;
    end
    if (cmd.op == DP_READ) begin
      live_q <= live_mem[cur_r[BLK_W-1:BOFF_W]];
      snap_q <= snap_mem[cur_r[BLK_W-1:BOFF_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else begin
      case (cmd.op)
        DP_FB_SET: fb_r <= cnt_r;
        DP_FB_SUB: fb_r <= fb_r - n_r;
        DP_FB_ADD: fb_r <= fb_r + n_r;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        func_r  <= in_func;
        start_r <= in_start;
        cnt_r   <= in_count;
        word_r  <= in_word;
        first_r <= '0;
        n_r     <= '0;
        was_r   <= '0;
        found_r <= 1'b0;
        bad_r   <= 1'b0;
        cont_r  <= 1'b0;
        cur_r   <= '0;
        lim_r   <= cnt_t'(GROUP_BITS);
      end
      DP_RANGE: begin
        case (cmd.rsel)
          RG_BMAP: begin
            cur_r <= {1'b0, cfg.block_map_pos};
            lim_r <= {1'b0, cfg.block_map_pos} + 1'b1;
          end
          RG_IMAP: begin
            cur_r <= {1'b0, cfg.inode_map_pos};
            lim_r <= {1'b0, cfg.inode_map_pos} + 1'b1;
          end
          RG_ITAB: begin
            cur_r <= tp16;
            lim_r <= tp16 + tl16;
          end
          RG_SCAN1: begin
            cur_r <= goal_ok ? start_r : '0;
            lim_r <= end_w;
          end
          RG_SCAN2: begin
            cur_r <= '0;
            lim_r <= (start_r < end_w) ? start_r : end_w;
          end
          RG_RUN: begin
            cur_r <= {1'b0, first_r};
            lim_r <= end_w;
            rem_r <= cnt_r;
            n_r   <= '0;
          end
          RG_UNDO: begin
            cur_r <= {1'b0, first_r};
            lim_r <= {1'b0, first_r} + n_r;
          end
          RG_FREE: begin
            cur_r <= start_r;
            lim_r <= start_r + cnt_r;
            n_r   <= '0;
            was_r <= '0;
          end
          default: begin
            cur_r <= '0;
            lim_r <= cnt_t'(GROUP_BITS);
          end
        endcase
      end
      DP_CHK: begin
        bad_r <= bad_r | ((live_q & mask) != mask);
        cur_r <= base + cnt_t'(WORD_BITS);
      end
      DP_FIND: begin
        found_r <= |find_v;
        first_r <= {cur_r[BLK_W-1:BOFF_W], fidx[BOFF_W-1:0]};
        cur_r   <= base + cnt_t'(WORD_BITS);
      end
      DP_CLAIM: begin
        cur_r  <= cur_r + k16;
        rem_r  <= rem_r - k16;
        n_r    <= n_r + k16;
        cont_r <= (k == room) && (rem_r != k16) && ((cur_r + k16) < lim_r);
      end
      DP_FREE: begin
        n_r   <= n_r + cnt_t'(popcount(live_q & mask));
        was_r <= was_r + cnt_t'(popcount(~live_q & mask));
        cur_r <= base + cnt_t'(WORD_BITS);
      end
      DP_UNDO, DP_COMMIT, DP_CLEAR: begin
        cur_r <= base + cnt_t'(WORD_BITS);
      end
      default: begin
      end
    endcase
  end

  // Result fields, zeroed where the operation reports none.
  always_comb begin
    logic ok, kept;
    ok   = cmd.code == ST_OK;
    kept = ok || (cmd.code == ST_COUNT);
    res.status       = cmd.code;
    res.first_block  = (func_r == FN_ALLOC && ok) ? first_r : '0;
    res.granted      = ((func_r == FN_ALLOC && ok) || (func_r == FN_FREE && kept)) ?
                       n_r : '0;
    res.already_free = (func_r == FN_FREE && kept) ? was_r : '0;
    res.free_count   = fb_r;
  end

endmodule

### rtl/dbba_ctrl.sv
module dbba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_full,
  input  dbba_pkg::dp_stat_t stat,
  output dbba_pkg::dp_cmd_t  cmd,
  output logic               in_ready,
  output logic               push
);
  import dbba_pkg::*;

  typedef enum logic [4:0] {
    S_CLR_INIT, S_CLR, S_IDLE, S_DISP,
    S_CHK_RD, S_CHK_PR, S_CHK_NX,
    S_SCAN_RD, S_SCAN_PR, S_SCAN_NX,
    S_RUN_RD, S_RUN_PR, S_RUN_NX, S_RUN_END,
    S_UNDO_RD, S_UNDO_PR, S_UNDO_NX,
    S_FREE_RD, S_FREE_PR, S_FREE_NX,
    S_CMT_RD, S_CMT_PR, S_CMT_NX,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  st_t code_r, code_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic pass_r, pass_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    sel_nxt   = sel_r;
    pass_nxt  = pass_r;
    cmd.op    = DP_NOP;
    cmd.rsel  = RG_ALL;
    cmd.code  = code_r;
    push      = 1'b0;
    unique case (state_r)
      S_CLR_INIT: begin
        cmd.op    = DP_RANGE;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        if (stat.done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        code_nxt  = ST_OK;
        sel_nxt   = 2'd0;
        case (stat.func)
          FN_ALLOC: begin
            if (stat.free_zero) begin
              code_nxt = ST_NO_SPACE;
            end else if (!stat.bounds_ok) begin
              code_nxt = ST_CORRUPT;
            end else begin
              cmd.op    = DP_RANGE;
              cmd.rsel  = RG_BMAP;
              state_nxt = S_CHK_RD;
            end
          end
          FN_FREE: begin
            if (stat.free_bad) begin
              code_nxt = ST_BAD_RANGE;
            end else if (stat.hits) begin
              code_nxt = ST_META;
            end else if (!stat.bounds_ok) begin
              code_nxt = ST_CORRUPT;
            end else begin
              cmd.op    = DP_RANGE;
              cmd.rsel  = RG_BMAP;
              state_nxt = S_CHK_RD;
            end
          end
          FN_COMMIT: begin
            cmd.op    = DP_RANGE;
            cmd.rsel  = RG_ALL;
            state_nxt = S_CMT_RD;
          end
          FN_LOAD: begin
            if (stat.load_bad) begin
              code_nxt = ST_BAD_RANGE;
            end else begin
              cmd.op = DP_LOAD;
            end
          end
          FN_SETCNT: cmd.op = DP_FB_SET;
          default:   code_nxt = ST_BAD_OP;
        endcase
      end
      S_CHK_RD: begin
        cmd.op    = DP_READ;
        state_nxt = S_CHK_PR;
      end
      S_CHK_PR: begin
        cmd.op    = DP_CHK;
        state_nxt = S_CHK_NX;
      end
      S_CHK_NX: begin
        if (stat.bad) begin
          code_nxt  = ST_CORRUPT;
          state_nxt = S_OUT;
        end else if (!stat.done) begin
          state_nxt = S_CHK_RD;
        end else if (sel_r == 2'd0) begin
          cmd.op    = DP_RANGE;
          cmd.rsel  = RG_IMAP;
          sel_nxt   = 2'd1;
          state_nxt = S_CHK_RD;
        end else if (sel_r == 2'd1) begin
          cmd.op    = DP_RANGE;
          cmd.rsel  = RG_ITAB;
          sel_nxt   = 2'd2;
          state_nxt = S_CHK_RD;
        end else if (stat.func == FN_ALLOC) begin
          if (stat.want_zero) begin
            code_nxt  = ST_NO_SPACE;
            state_nxt = S_OUT;
          end else begin
            cmd.op    = DP_RANGE;
            cmd.rsel  = RG_SCAN1;
            pass_nxt  = 1'b0;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          cmd.op    = DP_RANGE;
          cmd.rsel  = RG_FREE;
          state_nxt = S_FREE_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.op    = DP_READ;
        state_nxt = S_SCAN_PR;
      end
      S_SCAN_PR: begin
        cmd.op    = DP_FIND;
        state_nxt = S_SCAN_NX;
      end
      S_SCAN_NX: begin
        if (stat.found) begin
          cmd.op    = DP_RANGE;
          cmd.rsel  = RG_RUN;
          state_nxt = S_RUN_RD;
        end else if (!stat.done) begin
          state_nxt = S_SCAN_RD;
        end else if (!pass_r && stat.goal_pos) begin
          cmd.op    = DP_RANGE;
          cmd.rsel  = RG_SCAN2;
          pass_nxt  = 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          code_nxt  = ST_NO_SPACE;
          state_nxt = S_OUT;
        end
      end
      S_RUN_RD: begin
        cmd.op    = DP_READ;
        state_nxt = S_RUN_PR;
      end
      S_RUN_PR: begin
        cmd.op    = DP_CLAIM;
        state_nxt = S_RUN_NX;
      end
      S_RUN_NX: begin
        state_nxt = stat.cont ? S_RUN_RD : S_RUN_END;
      end
      S_RUN_END: begin
        if (stat.hits || stat.underflow) begin
          cmd.op    = DP_RANGE;
          cmd.rsel  = RG_UNDO;
          state_nxt = S_UNDO_RD;
        end else begin
          cmd.op    = DP_FB_SUB;
          code_nxt  = ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_UNDO_RD: begin
        cmd.op    = DP_READ;
        state_nxt = S_UNDO_PR;
      end
      S_UNDO_PR: begin
        cmd.op    = DP_UNDO;
        state_nxt = S_UNDO_NX;
      end
      S_UNDO_NX: begin
        if (!stat.done) begin
          state_nxt = S_UNDO_RD;
        end else begin
          code_nxt  = stat.hits ? ST_META : ST_COUNT;
          state_nxt = S_OUT;
        end
      end
      S_FREE_RD: begin
        cmd.op    = DP_READ;
        state_nxt = S_FREE_PR;
      end
      S_FREE_PR: begin
        cmd.op    = DP_FREE;
        state_nxt = S_FREE_NX;
      end
      S_FREE_NX: begin
        if (!stat.done) begin
          state_nxt = S_FREE_RD;
        end else if (stat.overflow) begin
          code_nxt  = ST_COUNT;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = DP_FB_ADD;
          code_nxt  = ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_CMT_RD: begin
        cmd.op    = DP_READ;
        state_nxt = S_CMT_PR;
      end
      S_CMT_PR: begin
        cmd.op    = DP_COMMIT;
        state_nxt = S_CMT_NX;
      end
      S_CMT_NX: begin
        state_nxt = stat.done ? S_OUT : S_CMT_RD;
      end
      S_OUT: begin
        if (!out_full) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR_INIT;
    endcase
  end

  assign in_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_INIT;
      code_r  <= ST_OK;
      sel_r   <= 2'd0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      sel_r   <= sel_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

### rtl/dual_bitmap_block_allocator_unit.sv
// Each item is handled by walking the bitmap words that it needs, one word after another.
// Allocate walks the metadata words, the search words (goal to end, then start) and the run.
// Free walks metadata and its range; commit walks all 1024 words.
// Items are taken one at a time; the single-ported bitmap memories set the word rate.
// Reset: synchronous, active low; a clearing pass then zeroes both maps,
// and no item is accepted until it ends. Configuration writes are taken at any time.
module dual_bitmap_block_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input item: func[2:0], start_req[18:3], count[34:19], data_word[66:35], zero pad.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  // Result item: status[2:0], first_block[17:3], granted[33:18],
  // already_free[49:34], free_count[65:50], zero pad.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dbba_pkg::*;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_GROUP_BLOCKS = 3'd0;
  localparam logic [2:0] REG_BLOCK_MAP    = 3'd1;
  localparam logic [2:0] REG_INODE_MAP    = 3'd2;
  localparam logic [2:0] REG_ITAB_POS     = 3'd3;
  localparam logic [2:0] REG_ITAB_LEN     = 3'd4;

  cfg_t cfg_r;
  dp_cmd_t cmd;
  dp_stat_t stat;
  result_t res;
  logic in_ready, push, out_full, cfg_wr;
  logic out_valid_r;
  result_t out_data_r;

  // The configuration registers sit here; the port never stalls.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_blocks    <= cnt_t'(GROUP_BITS);
      cfg_r.block_map_pos   <= blk_t'(0);
      cfg_r.inode_map_pos   <= blk_t'(1);
      cfg_r.inode_table_pos <= blk_t'(2);
      cfg_r.inode_table_len <= blk_t'(256);
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_GROUP_BLOCKS: cfg_r.group_blocks    <= cfg_pwdata[15:0];
        REG_BLOCK_MAP:    cfg_r.block_map_pos   <= cfg_pwdata[14:0];
        REG_INODE_MAP:    cfg_r.inode_map_pos   <= cfg_pwdata[14:0];
        REG_ITAB_POS:     cfg_r.inode_table_pos <= cfg_pwdata[14:0];
        REG_ITAB_LEN:     cfg_r.inode_table_len <= cfg_pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_GROUP_BLOCKS: cfg_prdata = {16'd0, cfg_r.group_blocks};
      REG_BLOCK_MAP:    cfg_prdata = {17'd0, cfg_r.block_map_pos};
      REG_INODE_MAP:    cfg_prdata = {17'd0, cfg_r.inode_map_pos};
      REG_ITAB_POS:     cfg_prdata = {17'd0, cfg_r.inode_table_pos};
      REG_ITAB_LEN:     cfg_prdata = {17'd0, cfg_r.inode_table_len};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // The sequencer drives the bitmap datapath word by word.
  dbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_full (out_full),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready),
    .push     (push)
  );

  dbba_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .in_func  (in_tdata[2:0]),
    .in_start (in_tdata[18:3]),
    .in_count (in_tdata[34:19]),
    .in_word  (in_tdata[66:35]),
    .stat     (stat),
    .res      (res)
  );

  assign in_tready = in_ready;

  // Output register: the result item waits here while the next item is accepted.
  assign out_full = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule

### rtl/dbba_checker.sv
`include "dual_bitmap_block_allocator_unit_macros.svh"

module dbba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // The clearing pass keeps the input closed right after reset.
  `DBBA_AST_RST(a_clear_after_reset, !rst_n, !in_tready)
  // Items are processed one at a time.
  `DBBA_AST_NXT(a_one_item, in_tvalid && in_tready, !in_tready)
  // A stalled result holds.
  `DBBA_AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Status never carries the unused code.
  `DBBA_AST_IMP(a_status_code, out_tvalid, out_tdata[2:0] != 3'd7)

endmodule

bind dual_bitmap_block_allocator_unit dbba_checker u_dbba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbba_pkg::*;

  // Register indexes on the configuration port; each register sits at byte address 4*index.
  localparam int REG_GROUP_BLOCKS = 0;
  localparam int REG_BMAP_POS     = 1;
  localparam int REG_IMAP_POS     = 2;
  localparam int REG_ITAB_POS     = 3;
  localparam int REG_ITAB_LEN     = 4;

  localparam int MAP_WORDS   = 1024;
  localparam int CYCLE_LIMIT = 25_000_000;
  localparam int HOLD_CYCLES = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dual_bitmap_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the allocator: configuration, both bitmaps and the free count.
  int        grp_blocks, bmap_pos, imap_pos, itab_pos, itab_len;
  bit [31:0] live_w [MAP_WORDS];
  bit [31:0] snap_w [MAP_WORDS];
  int        free_cnt;

  result_t pending_results[$];
  int      errors;
  int      items_sent;
  int      idle_mode;     // 0: sender 33% / receiver 52%, 1: swapped, 2: no idling
  bit      hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int group_end();
    return (grp_blocks > GROUP_BITS) ? GROUP_BITS : grp_blocks;
  endfunction

  // Blocks past the last map word read as set.
  function automatic bit map_bit(bit snap, int b);
    if (b / WORD_BITS >= MAP_WORDS) return 1'b1;
    return snap ? snap_w[b / WORD_BITS][b % WORD_BITS] : live_w[b / WORD_BITS][b % WORD_BITS];
  endfunction

  function automatic void put_live(int b, bit v);
    if (b / WORD_BITS < MAP_WORDS) live_w[b / WORD_BITS][b % WORD_BITS] = v;
  endfunction

  function automatic bit is_usable(int b);
    return !map_bit(1'b0, b) && !map_bit(1'b1, b);
  endfunction

  function automatic bit span_has(int b, int first, int len);
    return (len != 0) && (b >= first) && (b - first < len);
  endfunction

  // Both bitmap blocks and the whole inode table must be inside the group and marked used.
  function automatic bit metadata_intact();
    int e;
    e = group_end();
    if (bmap_pos >= e || !map_bit(1'b0, bmap_pos)) return 1'b0;
    if (imap_pos >= e || !map_bit(1'b0, imap_pos)) return 1'b0;
    if (itab_pos >= e || itab_len == 0 || itab_len > e - itab_pos) return 1'b0;
    for (int b = itab_pos; b < itab_pos + itab_len; b++)
      if (!map_bit(1'b0, b)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit touches_metadata(int first, int n);
    if (n == 0) return 1'b1;
    return span_has(bmap_pos, first, n) || span_has(imap_pos, first, n) ||
           span_has(first, itab_pos, itab_len) || span_has(first + n - 1, itab_pos, itab_len);
  endfunction

  function automatic int first_usable(int from, int upto);
    for (int b = from; b < upto; b++)
      if (is_usable(b)) return b;
    return -1;
  endfunction

  // Applies one item to the shadow state and returns the result the block must give.
  function automatic result_t allocator_outcome(logic [2:0] fn, logic [15:0] sraw,
                                                logic [15:0] cnt, logic [31:0] word);
    result_t r;
    st_t     st;
    int      sreq, e, n, f, b, freed, was;
    bit      ovl;
    sreq = int'($signed(sraw));
    e = group_end();
    st = ST_OK;
    r = '0;
    case (fn)
      FN_ALLOC: begin
        if (free_cnt == 0) st = ST_NO_SPACE;
        else if (!metadata_intact()) st = ST_CORRUPT;
        else if (cnt == 0) st = ST_NO_SPACE;
        else begin
          // First pass from the goal to the end; a positive goal wraps to the start.
          f = first_usable((sreq >= 0 && sreq < e) ? sreq : 0, e);
          if (f < 0 && sreq > 0) f = first_usable(0, (sreq < e) ? sreq : e);
          if (f < 0) st = ST_NO_SPACE;
          else begin
            n = 0;
            b = f;
            while (b < e && n < int'(cnt) && is_usable(b)) begin
              put_live(b, 1'b1);
              b++;
              n++;
            end
            if (touches_metadata(f, n) || free_cnt < n) begin
              ovl = touches_metadata(f, n);
              for (int i = 0; i < n; i++) put_live(f + i, 1'b0);
              st = ovl ? ST_META : ST_COUNT;
            end else begin
              free_cnt -= n;
              r.first_block = blk_t'(f);
              r.granted = cnt_t'(n);
            end
          end
        end
      end
      FN_FREE: begin
        if (cnt == 0 || sreq < 0 || sreq >= e || int'(cnt) > e - sreq) st = ST_BAD_RANGE;
        else if (touches_metadata(sreq, cnt)) st = ST_META;
        else if (!metadata_intact()) st = ST_CORRUPT;
        else begin
          freed = 0;
          was = 0;
          for (int i = 0; i < int'(cnt); i++) begin
            snap_w[(sreq + i) / WORD_BITS][(sreq + i) % WORD_BITS] = 1'b1;
            if (map_bit(1'b0, sreq + i)) begin
              put_live(sreq + i, 1'b0);
              freed++;
            end else was++;
          end
          r.granted = cnt_t'(freed);
          r.already_free = cnt_t'(was);
          // On overflow the bitmap changes stay but the count is left alone.
          if (freed != 0) begin
            if (free_cnt > 65535 - freed) st = ST_COUNT;
            else free_cnt += freed;
          end
        end
      end
      FN_COMMIT: snap_w = live_w;
      FN_LOAD: begin
        if (sreq < 0 || sreq >= MAP_WORDS) st = ST_BAD_RANGE;
        else begin
          live_w[sreq] = word;
          snap_w[sreq] = word;
        end
      end
      FN_SETCNT: free_cnt = cnt;
      default: st = ST_BAD_OP;
    endcase
    r.status = st;
    r.free_count = cnt_t'(free_cnt);
    return r;
  endfunction

  // Drives one item and records the result it must produce once it is taken.
  task automatic send_item(logic [2:0] fn, logic [15:0] s, logic [15:0] c, logic [31:0] w,
                           bit typed, result_t typed_res);
    result_t pr;
    int      pct;
    pct = (idle_mode == 0) ? 33 : (idle_mode == 1) ? 52 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {5'd0, w, c, s, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pr = allocator_outcome(fn, s, c, w);
    pending_results.push_back(typed ? typed_res : pr);
    items_sent++;
    idle_mode = (items_sent < 100) ? 0 : (items_sent < 200) ? 1 : 2;
    if (items_sent == 130) hold_request = 1'b1;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup and access cycle; written at the edge where psel, penable and pwrite are high.
  task automatic cfg_write(int idx, int val);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = 5'(4 * idx);
    cfg_pwdata = 32'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_GROUP_BLOCKS: grp_blocks = val & 16'hffff;
      REG_BMAP_POS:     bmap_pos = val & 15'h7fff;
      REG_IMAP_POS:     imap_pos = val & 15'h7fff;
      REG_ITAB_POS:     itab_pos = val & 15'h7fff;
      default:          itab_len = val & 15'h7fff;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // New setting, then load words that mark the metadata with sparse random filler, then a random free count.
  task automatic begin_phase(int g, int bm, int im, int it, int il);
    int        e;
    bit [31:0] mk;
    result_t   none;
    none = '0;
    wait_drained();
    cfg_write(REG_GROUP_BLOCKS, g);
    cfg_write(REG_BMAP_POS, bm);
    cfg_write(REG_IMAP_POS, im);
    cfg_write(REG_ITAB_POS, it);
    cfg_write(REG_ITAB_LEN, il);
    e = group_end();
    for (int w = 0; w * WORD_BITS < e; w++) begin
      mk = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (w * WORD_BITS + k == bm || w * WORD_BITS + k == im ||
            span_has(w * WORD_BITS + k, it, il)) mk[k] = 1'b1;
      end
      if (mk != 0 || e <= MAP_WORDS)
        send_item(FN_LOAD, 16'(w), 16'($urandom), mk | ($urandom & $urandom & $urandom),
                  1'b0, none);
    end
    send_item(FN_SETCNT, 16'($urandom), 16'($urandom_range(50, 2000)), $urandom, 1'b0, none);
  endtask

  task automatic random_items(int total);
    logic [2:0]  fn;
    logic [15:0] s, c;
    logic [31:0] w;
    int          r, e;
    result_t     none;
    none = '0;
    for (int i = 0; i < total; i++) begin
      e = group_end();
      r = $urandom_range(0, 99);
      w = $urandom;
      s = 16'($urandom_range(0, e - 1));
      c = 16'($urandom_range(1, 12));
      if (r < 45) begin
        fn = FN_ALLOC;
        case ($urandom_range(0, 9))
          0: s = 16'hffff;
          1: s = 16'($urandom);
          2: c = '0;
          3: c = 16'($urandom);
          default: ;
        endcase
      end else if (r < 72) begin
        fn = FN_FREE;
        case ($urandom_range(0, 9))
          0: s = 16'($urandom);
          1: c = 16'($urandom);
          default: ;
        endcase
      end else if (r < 80) begin
        fn = FN_LOAD;
        s = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, (e - 1) / 32));
      end else if (r < 88) begin
        fn = FN_SETCNT;
        case ($urandom_range(0, 3))
          0: c = 16'hffff - 16'($urandom_range(0, 20));
          1: c = 16'($urandom);
          default: c = 16'($urandom_range(1, 200));
        endcase
      end else if (r < 92) fn = FN_COMMIT;
      else if (r < 95) begin
        fn = 3'($urandom_range(5, 7));
        s = 16'($urandom);
        c = 16'($urandom);
      end else fn = FN_ALLOC;
      send_item(fn, s, c, w, 1'b0, none);
    end
  endtask

  // Receiver: random stalls per idle mode, plus one long hold-off that backs up the block.
  initial begin
    int hold_left;
    int pct;
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      pct = (idle_mode == 0) ? 52 : (idle_mode == 1) ? 33 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else out_tready = ($urandom_range(0, 99) >= pct);
    end
  end

  // Checker: every taken result is compared with the oldest pending one.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[65:0]);
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending: %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.first_block !== want.first_block) begin
          $error("first_block: expected %0d, got %0d", want.first_block, got.first_block);
          errors++;
        end
        if (got.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, got.granted);
          errors++;
        end
        if (got.already_free !== want.already_free) begin
          $error("already_free: expected %0d, got %0d", want.already_free, got.already_free);
          errors++;
        end
        if (got.free_count !== want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [2:0]  fn;
    logic [15:0] s;
    logic [15:0] c;
    logic [31:0] w;
    bit          typed;
    st_t         st;
    logic [15:0] fc;
  } dir_row_t;

  // Directed rows under the reset setting. Where typed is set, the whole result is known
  // up front (error paths and count writes); other rows go through the shadow model.
  dir_row_t dir_rows[$] = '{
    '{FN_ALLOC,  16'd0,     16'd1,     32'd0,        1, ST_NO_SPACE,  16'd0},
    '{FN_SETCNT, 16'd0,     16'hffff,  32'd0,        1, ST_OK,        16'hffff},
    '{FN_ALLOC,  16'd0,     16'd1,     32'd0,        1, ST_CORRUPT,   16'hffff},
    '{FN_FREE,   16'hffff,  16'd1,     32'd0,        1, ST_BAD_RANGE, 16'hffff},
    '{FN_FREE,   16'd0,     16'd0,     32'd0,        1, ST_BAD_RANGE, 16'hffff},
    '{FN_FREE,   16'd32767, 16'd2,     32'd0,        1, ST_BAD_RANGE, 16'hffff},
    '{FN_FREE,   16'd0,     16'd1,     32'd0,        1, ST_META,      16'hffff},
    '{3'd7,      16'hffff,  16'hffff,  32'hffffffff, 1, ST_BAD_OP,    16'hffff},
    '{FN_LOAD,   16'd1024,  16'd0,     32'd0,        1, ST_BAD_RANGE, 16'hffff},
    '{FN_LOAD,   16'hffff,  16'd0,     32'd0,        1, ST_BAD_RANGE, 16'hffff},
    '{FN_LOAD,   16'd0,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd1,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd2,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd3,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd4,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd5,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd6,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd7,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_LOAD,   16'd8,     16'd0,     32'hffffffff, 0, ST_OK,        16'd0},
    '{FN_ALLOC,  16'hffff,  16'd0,     32'd0,        1, ST_NO_SPACE,  16'hffff},
    '{FN_ALLOC,  16'd300,   16'hffff,  32'd0,        0, ST_OK,        16'd0},
    '{FN_FREE,   16'd300,   16'd10,    32'd0,        0, ST_OK,        16'd0},
    '{FN_SETCNT, 16'd0,     16'hffff,  32'd0,        1, ST_OK,        16'hffff},
    '{FN_FREE,   16'd310,   16'd4,     32'd0,        0, ST_OK,        16'd0},
    '{FN_COMMIT, 16'd0,     16'd0,     32'd0,        0, ST_OK,        16'd0},
    '{FN_ALLOC,  16'd32767, 16'd3,     32'd0,        0, ST_OK,        16'd0},
    '{FN_SETCNT, 16'd0,     16'd2,     32'd0,        1, ST_OK,        16'd2},
    '{FN_ALLOC,  16'd288,   16'd5,     32'd0,        0, ST_OK,        16'd0}
  };

  task automatic random_layout(int g, int n);
    int il, it;
    il = $urandom_range(1, 8);
    it = $urandom_range(0, g - il);
    begin_phase(g, $urandom_range(0, g - 1), $urandom_range(0, g - 1), it, il);
    random_items(n);
  endtask

  initial begin
    result_t typed_res;
    errors = 0;
    items_sent = 0;
    idle_mode = 0;
    hold_request = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    grp_blocks = 32768;
    bmap_pos = 0;
    imap_pos = 1;
    itab_pos = 2;
    itab_len = 256;
    free_cnt = 0;
    foreach (live_w[i]) begin
      live_w[i] = '0;
      snap_w[i] = '0;
    end
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      typed_res = '0;
      typed_res.status = dir_rows[i].st;
      typed_res.free_count = dir_rows[i].fc;
      send_item(dir_rows[i].fn, dir_rows[i].s, dir_rows[i].c, dir_rows[i].w,
                dir_rows[i].typed, typed_res);
    end

    random_layout(256, 70);
    // Single-block group: every metadata position lands on block zero.
    begin_phase(1, 0, 0, 0, 1);
    random_items(8);
    // Count above the bitmap size acts as the full group; metadata at the top end.
    begin_phase(16'hffff, 32767, 32766, 32000, 767);
    random_items(20);
    // The sender holds back until every pending result has come out.
    wait_drained();
    // An inode table far longer than the group always fails the metadata bounds check.
    begin_phase(300, 5, 6, 10, 32767);
    random_items(10);
    random_layout(100, 70);
    random_layout(512, 15);

    wait_drained();
    repeat (200) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dbba_pkg.sv
rtl/dbba_dp.sv
rtl/dbba_ctrl.sv
rtl/dual_bitmap_block_allocator_unit.sv
rtl/dbba_checker.sv
tb/tb.sv
